FILE: rtl/core/rv32i_ex_pkg.sv
// Shared types and constants for the RV32I integer execute unit.
package rv32i_ex_pkg;

  localparam int XLEN       = 32;
  localparam int REG_COUNT  = 32;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int SHAMT_W    = 5;
  localparam int UPPER_SHIFT = 12;
  localparam int OP_W       = 5;
  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

  typedef enum logic [OP_W-1:0] {
    OP_ADDI  = 5'd0,
    OP_SLTI  = 5'd1,
    OP_SLTIU = 5'd2,
    OP_ANDI  = 5'd3,
    OP_ORI   = 5'd4,
    OP_XORI  = 5'd5,
    OP_SLLI  = 5'd6,
    OP_SRLI  = 5'd7,
    OP_SRAI  = 5'd8,
    OP_ADD   = 5'd9,
    OP_SLT   = 5'd10,
    OP_SLTU  = 5'd11,
    OP_AND   = 5'd12,
    OP_OR    = 5'd13,
    OP_XOR   = 5'd14,
    OP_SLL   = 5'd15,
    OP_SRL   = 5'd16,
    OP_SUB   = 5'd17,
    OP_SRA   = 5'd18,
    OP_NOP   = 5'd19,
    OP_HINT  = 5'd20,
    OP_JAL   = 5'd21,
    OP_LUI   = 5'd22,
    OP_AUIPC = 5'd23
  } opcode_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [REG_IDX_W-1:0] src1_index;
    logic [REG_IDX_W-1:0] src2_index;
    logic [REG_IDX_W-1:0] dest_index;
    logic [XLEN-1:0]      immediate;
  } instr_t;

  typedef struct packed {
    logic                 write_enable;
    logic [REG_IDX_W-1:0] write_index;
    logic [XLEN-1:0]      write_value;
    logic [XLEN-1:0]      next_pc;
  } result_t;

endpackage

FILE: rtl/core/rv32i_ex_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface rv32i_ex_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/rv32i_ex_alu.sv
// Integer ALU, jump and upper-immediate result for one decoded instruction.
module rv32i_ex_alu (
  input  logic [rv32i_ex_pkg::OP_W-1:0]      op,
  input  logic [rv32i_ex_pkg::REG_IDX_W-1:0] dest_index,
  input  logic [rv32i_ex_pkg::XLEN-1:0]      immediate,
  input  logic [rv32i_ex_pkg::XLEN-1:0]      src1,
  input  logic [rv32i_ex_pkg::XLEN-1:0]      src2,
  input  logic [rv32i_ex_pkg::XLEN-1:0]      pc,
  output rv32i_ex_pkg::result_t              res
);
  import rv32i_ex_pkg::*;

  logic [XLEN-1:0]    value;
  logic [XLEN-1:0]    next_pc;
  logic [XLEN-1:0]    upper;
  logic [SHAMT_W-1:0] shamt_i;
  logic [SHAMT_W-1:0] shamt_r;
  logic               writes;

  assign upper   = immediate << UPPER_SHIFT;
  assign shamt_i = immediate[SHAMT_W-1:0];
  assign shamt_r = src2[SHAMT_W-1:0];

  always_comb begin
    value   = '0;
    next_pc = pc + PC_STEP;
    writes  = 1'b1;
    case (opcode_t'(op))
      OP_ADDI:  value = src1 + immediate;
      OP_SLTI:  value = XLEN'($signed(src1) < $signed(immediate));
      OP_SLTIU: value = XLEN'(src1 < immediate);
      OP_ANDI:  value = src1 & immediate;
      OP_ORI:   value = src1 | immediate;
      OP_XORI:  value = src1 ^ immediate;
      OP_SLLI:  value = src1 << shamt_i;
      OP_SRLI:  value = src1 >> shamt_i;
      OP_SRAI:  value = XLEN'($signed(src1) >>> shamt_i);
      OP_ADD:   value = src1 + src2;
      OP_SLT:   value = XLEN'($signed(src1) < $signed(src2));
      OP_SLTU:  value = XLEN'(src1 < src2);
      OP_AND:   value = src1 & src2;
      OP_OR:    value = src1 | src2;
      OP_XOR:   value = src1 ^ src2;
      OP_SLL:   value = src1 << shamt_r;
      OP_SRL:   value = src1 >> shamt_r;
      OP_SUB:   value = src1 - src2;
      OP_SRA:   value = XLEN'($signed(src1) >>> shamt_r);
      OP_JAL: begin
        value   = pc + PC_STEP;
        next_pc = pc + immediate;
      end
      OP_LUI:   value = upper;
      OP_AUIPC: value = upper + pc;
      default:  writes = 1'b0;
    endcase
  end

  always_comb begin
    res.write_enable = writes && (dest_index != '0);
    res.write_index  = res.write_enable ? dest_index : '0;
    res.write_value  = res.write_enable ? value : '0;
    res.next_pc      = next_pc;
  end

endmodule

FILE: rtl/core/rv32i_integer_execute_unit.sv
// RV32I integer execute unit: one decoded instruction in, one register write and next pc out.
// Each item moves through the unit in order: the register file is read into the
// operand registers as the item is accepted, the ALU works on the operand registers, and the
// result register presents the write and the next pc. One item is accepted every cycle while
// the pipeline has room or the result is taken; a result committed in the same cycle as an
// acceptance is forwarded to the new item's operands. The register file is 32 x 32 bits with a
// valid bit per entry, so reset clears it at once; x0 always reads zero. The pc resets to zero.
module rv32i_integer_execute_unit (
  input logic clk,
  input logic rst,
  rv32i_ex_chan_if.sink   instr,
  rv32i_ex_chan_if.source result
);
  import rv32i_ex_pkg::*;

  logic [XLEN-1:0]      rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;
  logic [XLEN-1:0]      pc;

  logic                 stage_valid;
  logic [OP_W-1:0]      stage_op;
  logic [REG_IDX_W-1:0] stage_dest;
  logic [XLEN-1:0]      stage_imm;
  logic [XLEN-1:0]      src1;
  logic [XLEN-1:0]      src2;

  logic                 out_valid;
  result_t              out_item;
  result_t              alu_res;

  logic                 advance;
  logic                 commit;
  logic                 accept;
  logic                 fwd1;
  logic                 fwd2;
  instr_t               in_item;

  assign in_item = instr.payload;
  assign advance = !out_valid || result.ready;
  assign commit  = stage_valid && advance;
  assign accept  = instr.valid && instr.ready;
  assign instr.ready = !stage_valid || advance;

  assign fwd1 = commit && alu_res.write_enable && (alu_res.write_index == in_item.src1_index);
  assign fwd2 = commit && alu_res.write_enable && (alu_res.write_index == in_item.src2_index);

  rv32i_ex_alu u_alu (
    .op         (stage_op),
    .dest_index (stage_dest),
    .immediate  (stage_imm),
    .src1       (src1),
    .src2       (src2),
    .pc         (pc),
    .res        (alu_res)
  );

  always_ff @(posedge clk) begin
    if (commit && alu_res.write_enable) begin
      rf[alu_res.write_index] <= alu_res.write_value;
    end
    if (accept) begin
      stage_op   <= in_item.op;
      stage_dest <= in_item.dest_index;
      stage_imm  <= in_item.immediate;
      if (fwd1) begin
        src1 <= alu_res.write_value;
      end else if (rf_valid[in_item.src1_index]) begin
        src1 <= rf[in_item.src1_index];
      end else begin
        src1 <= '0;
      end
      if (fwd2) begin
        src2 <= alu_res.write_value;
      end else if (rf_valid[in_item.src2_index]) begin
        src2 <= rf[in_item.src2_index];
      end else begin
        src2 <= '0;
      end
    end
    if (commit) begin
      out_item <= alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid    <= '0;
      pc          <= '0;
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (commit) begin
        pc <= alu_res.next_pc;
        if (alu_res.write_enable) begin
          rf_valid[alu_res.write_index] <= 1'b1;
        end
      end
      if (instr.ready) begin
        stage_valid <= instr.valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;

`ifndef SYNTHESIS
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.write_enable && (out_item.write_index == '0)))
    else $error("write to x0 presented");

  a_x0_never_valid: assert property (@(posedge clk) disable iff (rst)
    !rf_valid[0])
    else $error("x0 marked as written");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !instr.ready |-> (stage_valid && out_valid && !result.ready))
    else $error("input stalled with room in the pipeline");

  a_pc_follows_commit: assert property (@(posedge clk) disable iff (rst)
    commit |=> (pc == $past(alu_res.next_pc)))
    else $error("pc did not take committed next pc");
`endif

endmodule
